FILE: hdl/esc_pkg.sv
// shared types and constants of the environmental sensor compensation unit
// no dependencies; used by esc_div64, esc_press and the top level
package esc_pkg;

	// transaction payloads
	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
		logic [15:0] raw_hum;
	} in_t;

	typedef struct packed {
		logic signed [31:0] temp_centi_degc;
		logic [31:0]        press_q24_8;
		logic [16:0]        hum_q22_10;
	} out_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CfgTempCalib   = 3'd0,
		CfgPressCalibA = 3'd1,
		CfgPressCalibB = 3'd2,
		CfgPressCalibC = 3'd3,
		CfgHumCalib    = 3'd4
	} cfg_idx_t;

	// pressure calibration words as held in configuration
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [15:0] c;
	} press_cal_t;

	// pipeline depths
	localparam int DivW     = 64;
	localparam int MulLat   = 2;
	localparam int DivLat   = DivW + 2;
	localparam int PressLat = 5 + 5 * MulLat + DivLat;

	// compensation constants
	localparam logic [63:0] PressTfOff = 64'd128000;
	localparam logic [63:0] PressBase  = 64'd1048576;
	localparam logic [63:0] PressScale = 64'd3125;
	localparam logic [31:0] HumTfOff   = 32'd76800;
	localparam logic [31:0] HumXRnd    = 32'd16384;
	localparam logic [31:0] HumBOff    = 32'd32768;
	localparam logic [31:0] HumY1Off   = 32'd2097152;
	localparam logic [31:0] HumYRnd    = 32'd8192;
	localparam logic [31:0] HumMax     = 32'd419430400;

endpackage

FILE: hdl/esc_delay.sv
// fixed-length delay line for payload alignment
// no dependencies
module esc_delay #(
	parameter int W = 32,
	parameter int D = 2
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] line_q [D];

	always_ff @(posedge clk) begin
		line_q[0] <= din;
		for (int i = 1; i < D; i++) begin
			line_q[i] <= line_q[i-1];
		end
	end

	assign dout = line_q[D-1];

endmodule

FILE: hdl/esc_mul64.sv
// 64x64 multiplier, low 64 bits, two stages built from 32x32 partial products
// no dependencies (latency must equal esc_pkg::MulLat)
module esc_mul64 (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;

	always_ff @(posedge clk) begin
		ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
		lh_s1 <= a[31:0] * b[63:32];
		hl_s1 <= a[63:32] * b[31:0];
		p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
	end

	assign p = p_s2;

endmodule

FILE: hdl/esc_div64.sv
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
// depends on esc_pkg (DivW)
module esc_div64 (
	input  logic        clk,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic [63:0] quo
);

	localparam int W = esc_pkg::DivW;

	logic [W-1:0] rem_s [W+1];
	logic [W-1:0] nq_s  [W+1];
	logic [W-1:0] ad_s  [W+1];
	logic         neg_s [W+1];
	logic [W-1:0] quo_q;

	// sign handling
	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		nq_s[0]  <= num[W-1] ? (W'(0) - num) : num;
		ad_s[0]  <= den[W-1] ? (W'(0) - den) : den;
		neg_s[0] <= num[W-1] ^ den[W-1];
	end

	for (genvar i = 0; i < W; i++) begin : g_step
		logic [W-1:0] trial;
		logic         ge;

		always_comb begin
			trial = {rem_s[i][W-2:0], nq_s[i][W-1]};
			ge    = (trial >= ad_s[i]);
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? (trial - ad_s[i]) : trial;
			nq_s[i+1]  <= {nq_s[i][W-2:0], ge};
			ad_s[i+1]  <= ad_s[i];
			neg_s[i+1] <= neg_s[i];
		end
	end

	always_ff @(posedge clk) begin
		quo_q <= neg_s[W] ? (W'(0) - nq_s[W]) : nq_s[W];
	end

	assign quo = quo_q;

endmodule

FILE: hdl/esc_press.sv
// pressure compensation pipeline, 64-bit wrapping arithmetic
// depends on esc_pkg, esc_mul64, esc_div64, esc_delay
module esc_press (
	input  logic                clk,
	input  logic [31:0]         tf,
	input  logic [19:0]         rp,
	input  esc_pkg::press_cal_t cal,
	output logic [31:0]         press
);

	localparam int M = esc_pkg::MulLat;

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [63:0] a_s1, pr_s1;
	logic [63:0] aa, ap5, ap2, aap6, aap3, ap5_d, ap2_d;
	logic [63:0] b_s6, x_s6, pr_d, n0_s7;
	logic [63:0] a3raw, n, a3_s9;
	logic [63:0] q, q13, q13_d, t1, t2, pb, pb_d, q_d;
	logic        zero_d;
	logic [63:0] sum_q;
	logic [31:0] press_q;

	always_comb begin
		p1 = 64'(cal.a[15:0]);
		p2 = 64'($signed(cal.a[31:16]));
		p3 = 64'($signed(cal.a[47:32]));
		p4 = 64'($signed(cal.a[63:48]));
		p5 = 64'($signed(cal.b[15:0]));
		p6 = 64'($signed(cal.b[31:16]));
		p7 = 64'($signed(cal.b[47:32]));
		p8 = 64'($signed(cal.b[63:48]));
		p9 = 64'($signed(cal.c));
	end

	always_ff @(posedge clk) begin
		a_s1  <= 64'($signed(tf)) - esc_pkg::PressTfOff;
		pr_s1 <= esc_pkg::PressBase - 64'(rp);
	end

	esc_mul64 u_aa  (.clk(clk), .a(a_s1), .b(a_s1), .p(aa));
	esc_mul64 u_ap5 (.clk(clk), .a(a_s1), .b(p5),   .p(ap5));
	esc_mul64 u_ap2 (.clk(clk), .a(a_s1), .b(p2),   .p(ap2));
	esc_mul64 u_aap6 (.clk(clk), .a(aa), .b(p6), .p(aap6));
	esc_mul64 u_aap3 (.clk(clk), .a(aa), .b(p3), .p(aap3));
	esc_delay #(.W(64), .D(M)) u_dap5 (.clk(clk), .din(ap5), .dout(ap5_d));
	esc_delay #(.W(64), .D(M)) u_dap2 (.clk(clk), .din(ap2), .dout(ap2_d));
	esc_delay #(.W(64), .D(2*M+1)) u_dpr (.clk(clk), .din(pr_s1), .dout(pr_d));

	// offset and sensitivity terms
	always_ff @(posedge clk) begin
		b_s6  <= aap6 + (ap5_d << 17) + (p4 << 35);
		x_s6  <= 64'($signed(aap3) >>> 8) + (ap2_d << 12) + (64'd1 << 47);
		n0_s7 <= (pr_d << 31) - b_s6;
	end

	esc_mul64 u_xp1 (.clk(clk), .a(x_s6), .b(p1), .p(a3raw));
	esc_mul64 u_n   (.clk(clk), .a(n0_s7), .b(esc_pkg::PressScale), .p(n));

	always_ff @(posedge clk) begin
		a3_s9 <= 64'($signed(a3raw) >>> 33);
	end

	esc_div64 u_div (.clk(clk), .num(n), .den(a3_s9), .quo(q));
	esc_delay #(.W(1), .D(esc_pkg::DivLat + 2*M + 1)) u_dzero (
		.clk(clk), .din(a3_s9 == 64'd0), .dout(zero_d)
	);

	assign q13 = 64'($signed(q) >>> 13);

	esc_mul64 u_t1 (.clk(clk), .a(p9), .b(q13), .p(t1));
	esc_delay #(.W(64), .D(M)) u_dq13 (.clk(clk), .din(q13), .dout(q13_d));
	esc_mul64 u_t2 (.clk(clk), .a(t1), .b(q13_d), .p(t2));
	esc_mul64 u_pb (.clk(clk), .a(p8), .b(q), .p(pb));
	esc_delay #(.W(64), .D(M)) u_dpb (.clk(clk), .din(pb), .dout(pb_d));
	esc_delay #(.W(64), .D(2*M)) u_dq (.clk(clk), .din(q), .dout(q_d));

	always_ff @(posedge clk) begin
		sum_q   <= q_d + 64'($signed(t2) >>> 25) + 64'($signed(pb_d) >>> 19);
		press_q <= zero_d ? 32'd0 : 32'(64'($signed(sum_q) >>> 8) + (p7 << 4));
	end

	assign press = press_q;

endmodule

FILE: hdl/env_sensor_compensation_unit.sv
// top level of the environmental sensor compensation unit
// depends on esc_pkg, esc_press, esc_delay
//
// usage:
//  - configuration: write cfg_wdata to register cfg_index when cfg_we is high
//    (0 temp_calib, 1 press_calib_a, 2 press_calib_b, 3 press_calib_c,
//    4 hum_calib); other indexes are ignored; write only while idle
//  - input: a raw triple on in_data is taken at a clock edge with start high
//    and busy low; busy is always low, so one transaction per cycle is taken
//  - output: done pulses for one cycle with the compensated triple on result
//  - done and result are registered together at the end of the aligned pressure
//    path; throughput one transaction per cycle
//  - the pressure path sets the latency: a one-bit-per-stage signed 64-bit
//    divider plus 64-bit multiplies split into 32-bit partial products
//  - temperature and humidity finish early and wait in delay lines
//  - reset clears the valid chain and all calibration words to zero
//  - the receiver has no back-pressure: each result is shown exactly once
module env_sensor_compensation_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  esc_pkg::in_t  in_data,
	output logic          done,
	output esc_pkg::out_t result,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_wdata
);

	localparam int PL = esc_pkg::PressLat;

	// calibration registers
	logic [47:0] temp_calib_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_c_q;
	logic [63:0] hum_calib_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
			hum_calib_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				esc_pkg::CfgTempCalib:   temp_calib_q <= cfg_wdata[47:0];
				esc_pkg::CfgPressCalibA: press_a_q    <= cfg_wdata;
				esc_pkg::CfgPressCalibB: press_b_q    <= cfg_wdata;
				esc_pkg::CfgPressCalibC: press_c_q    <= cfg_wdata[15:0];
				esc_pkg::CfgHumCalib:    hum_calib_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid chain
	logic          vld_s1, vld_s2, vld_s3;
	logic [PL-1:0] vld_pipe_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_pipe_q <= '0;
			done_q     <= 1'b0;
		end else begin
			vld_s1     <= start && !busy;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_pipe_q <= {vld_pipe_q[PL-2:0], vld_s3};
			done_q     <= vld_pipe_q[PL-1];
		end
	end

	// temperature calibration fields
	logic [31:0] t1, t2, t3, d;
	always_comb begin
		t1 = 32'(temp_calib_q[15:0]);
		t2 = 32'($signed(temp_calib_q[31:16]));
		t3 = 32'($signed(temp_calib_q[47:32]));
		d  = 32'(in_data.raw_temp[19:4]) - t1;
	end

	// temperature stages: fine temperature at s3, temperature in 0.01 degC at s4
	logic [31:0] m1_s1, dd_s1, v1_s2, m3_s2, tf_s3, temp_s4, hv_s4;
	logic [19:0] rp_s1, rp_s2, rp_s3;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4, rh_s5;

	always_ff @(posedge clk) begin
		m1_s1   <= (32'(in_data.raw_temp[19:3]) - (t1 << 1)) * t2;
		dd_s1   <= d * d;
		rp_s1   <= in_data.raw_press;
		rh_s1   <= in_data.raw_hum;
		v1_s2   <= 32'($signed(m1_s1) >>> 11);
		m3_s2   <= 32'($signed(dd_s1) >>> 12) * t3;
		rp_s2   <= rp_s1;
		rh_s2   <= rh_s1;
		tf_s3   <= v1_s2 + 32'($signed(m3_s2) >>> 14);
		rp_s3   <= rp_s2;
		rh_s3   <= rh_s2;
		temp_s4 <= 32'($signed(tf_s3 * 32'd5 + 32'd128) >>> 8);
		hv_s4   <= tf_s3 - esc_pkg::HumTfOff;
		rh_s4   <= rh_s3;
		rh_s5   <= rh_s4;
	end

	// pressure path shares the fine temperature
	esc_pkg::press_cal_t pcal;
	logic [31:0]         press;

	assign pcal = '{a: press_a_q, b: press_b_q, c: press_c_q};

	esc_press u_press (
		.clk(clk), .tf(tf_s3), .rp(rp_s3), .cal(pcal), .press(press)
	);

	// humidity calibration fields
	logic [31:0] h1, h2, h3, h4, h5, h6;
	always_comb begin
		h1 = 32'(hum_calib_q[7:0]);
		h2 = 32'($signed(hum_calib_q[23:8]));
		h3 = 32'(hum_calib_q[31:24]);
		h4 = 32'($signed(hum_calib_q[43:32]));
		h5 = 32'($signed(hum_calib_q[55:44]));
		h6 = 32'($signed(hum_calib_q[63:56]));
	end

	// humidity stages s5 to s14, built from registered 32-bit multiplies
	logic [31:0] m5_s5, m6_s5, mh3_s5;
	logic [31:0] hx_s6, a6_s6, b3_s6;
	logic [31:0] y0_s7, hx_s7, y1_s8, hx_s8, y2_s9, hx_s9, y_s10, hx_s10;
	logic [31:0] hv2_s11, ss_s12, hv2_s12, k_s13, hv2_s13;
	logic [31:0] hs, hr;
	logic [16:0] hum_s14, hum_d;

	always_comb begin
		hs = 32'($signed(hv2_s11) >>> 15);
		hr = hv2_s13 - 32'($signed(k_s13) >>> 4);
	end

	always_ff @(posedge clk) begin
		m5_s5   <= h5 * hv_s4;
		m6_s5   <= hv_s4 * h6;
		mh3_s5  <= hv_s4 * h3;
		hx_s6   <= 32'($signed((32'(rh_s5) << 14) - (h4 << 20) - m5_s5
			+ esc_pkg::HumXRnd) >>> 15);
		a6_s6   <= 32'($signed(m6_s5) >>> 10);
		b3_s6   <= 32'($signed(mh3_s5) >>> 11) + esc_pkg::HumBOff;
		y0_s7   <= a6_s6 * b3_s6;
		hx_s7   <= hx_s6;
		y1_s8   <= 32'($signed(y0_s7) >>> 10) + esc_pkg::HumY1Off;
		hx_s8   <= hx_s7;
		y2_s9   <= y1_s8 * h2;
		hx_s9   <= hx_s8;
		y_s10   <= 32'($signed(y2_s9 + esc_pkg::HumYRnd) >>> 14);
		hx_s10  <= hx_s9;
		hv2_s11 <= hx_s10 * y_s10;
		ss_s12  <= hs * hs;
		hv2_s12 <= hv2_s11;
		k_s13   <= 32'($signed(ss_s12) >>> 7) * h1;
		hv2_s13 <= hv2_s12;
		// clamp to 0..100 %RH before dropping the 12 fraction bits
		if (hr[31]) begin
			hum_s14 <= '0;
		end else if (hr > esc_pkg::HumMax) begin
			hum_s14 <= esc_pkg::HumMax[28:12];
		end else begin
			hum_s14 <= hr[28:12];
		end
	end

	// align temperature and humidity with pressure
	logic [31:0] temp_d;
	esc_delay #(.W(32), .D(PL - 1))  u_dtemp (.clk(clk), .din(temp_s4), .dout(temp_d));
	esc_delay #(.W(17), .D(PL - 11)) u_dhum  (.clk(clk), .din(hum_s14), .dout(hum_d));

	esc_pkg::out_t result_q;
	always_ff @(posedge clk) begin
		result_q.temp_centi_degc <= $signed(temp_d);
		result_q.press_q24_8     <= press;
		result_q.hum_q22_10      <= hum_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: sim/env_sensor_compensation_unit_tb.sv
// testbench of the environmental sensor compensation unit
// depends on esc_pkg and env_sensor_compensation_unit; self-checking
`timescale 1ns / 100ps

module env_sensor_compensation_unit_tb;

	localparam int LatCycles = 4 + esc_pkg::PressLat;
	localparam int WatchdogLimit = 4000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	esc_pkg::in_t  in_data;
	logic          done;
	esc_pkg::out_t result;
	logic          cfg_we;
	logic [2:0]    cfg_index;
	logic [63:0]   cfg_wdata;

	// local copy of the calibration words
	logic [47:0] cal_temp;
	logic [63:0] cal_press_a;
	logic [63:0] cal_press_b;
	logic [15:0] cal_press_c;
	logic [63:0] cal_hum;

	esc_pkg::out_t compensated_q[$];
	int            mismatch_cnt;
	int            idle_cycles;
	bit            timed_out;
	int            send_idle_pct;

	env_sensor_compensation_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.in_data  (in_data),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// signed 64-bit division truncating toward zero, wrapping on overflow
	function automatic logic [63:0] div_trunc64(logic [63:0] num, logic [63:0] den);
		logic [63:0] an;
		logic [63:0] ad;
		logic [63:0] q;
		an = num[63] ? -num : num;
		ad = den[63] ? -den : den;
		q = an / ad;
		return (num[63] != den[63]) ? -q : q;
	endfunction

	// integer compensation of one raw triple with the current calibration
	function automatic esc_pkg::out_t compensate(esc_pkg::in_t raw);
		esc_pkg::out_t r;
		logic signed [31:0] t1, t2, t3, v1, d, v2, tf;
		logic signed [63:0] a, b, p, p1, p2, p3, p4, p5, p6, p7, p8, p9, pd;
		logic signed [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, hs, rt, rh;
		rt = {12'd0, raw.raw_temp};
		rh = {16'd0, raw.raw_hum};
		t1 = {16'd0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		v1 = (((rt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (rt >>> 4) - t1;
		v2 = (((d * d) >>> 12) * t3) >>> 14;
		tf = v1 + v2;
		r.temp_centi_degc = (tf * 5 + 128) >>> 8;

		p1 = {48'd0, cal_press_a[15:0]};
		p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
		p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
		p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
		p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
		p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
		p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
		p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
		p9 = {{48{cal_press_c[15]}}, cal_press_c};
		a = {{32{tf[31]}}, tf} - 64'sd128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		if (a == 0) begin
			r.press_q24_8 = '0;
		end else begin
			p = 64'sd1048576 - {44'd0, raw.raw_press};
			p = div_trunc64(((p <<< 31) - b) * 64'sd3125, a);
			pd = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			p = ((p + pd + b) >>> 8) + (p7 <<< 4);
			r.press_q24_8 = p[31:0];
		end

		h1 = {24'd0, cal_hum[7:0]};
		h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
		h3 = {24'd0, cal_hum[31:24]};
		h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
		h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
		h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
		hv = tf - 32'sd76800;
		hx = ((rh <<< 14) - (h4 <<< 20) - h5 * hv + 32'sd16384) >>> 15;
		hy = ((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32'sd32768);
		hy = (hy >>> 10) + 32'sd2097152;
		hy = (hy * h2 + 32'sd8192) >>> 14;
		hv = hx * hy;
		hs = hv >>> 15;
		hv = hv - ((((hs * hs) >>> 7) * h1) >>> 4);
		if (hv < 0)
			hv = 0;
		else if (hv > 32'sd419430400)
			hv = 32'sd419430400;
		r.hum_q22_10 = hv[28:12];
		return r;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		esc_pkg::out_t want;
		if (arst_n) begin
			if (done) begin
				if (compensated_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result %h", result);
				end else begin
					want = compensated_q.pop_front();
					if (result.temp_centi_degc !== want.temp_centi_degc
							|| result.press_q24_8 !== want.press_q24_8
							|| result.hum_q22_10 !== want.hum_q22_10) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display({"mismatch: temp exp %0d got %0d, ",
								"press exp %h got %h, hum exp %h got %h"},
								want.temp_centi_degc, result.temp_centi_degc,
								want.press_q24_8, result.press_q24_8,
								want.hum_q22_10, result.hum_q22_10);
					end
				end
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchdogLimit)
				timed_out = 1'b1;
		end
	end

	// one transaction, with a random gap before it; start stays high on return
	task automatic send_triple(esc_pkg::in_t raw);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		in_data <= raw;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		compensated_q.push_back(compensate(raw));
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (compensated_q.size() != 0 && !timed_out)
			@(negedge clk);
		repeat (LatCycles + 4) @(negedge clk);
	endtask

	// register write while the unit is idle
	task automatic write_cfg(esc_pkg::cfg_idx_t idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			esc_pkg::CfgTempCalib:   cal_temp = val[47:0];
			esc_pkg::CfgPressCalibA: cal_press_a = val;
			esc_pkg::CfgPressCalibB: cal_press_b = val;
			esc_pkg::CfgPressCalibC: cal_press_c = val[15:0];
			esc_pkg::CfgHumCalib:    cal_hum = val;
			default: ;
		endcase
	endtask

	// typical datasheet-like calibration
	task automatic load_typical_cal();
		write_cfg(esc_pkg::CfgTempCalib, 64'({16'hFF83, 16'h6A3B, 16'd27504}));
		write_cfg(esc_pkg::CfgPressCalibA, {16'h0B71, 16'hFB63, 16'h6B4A, 16'd36477});
		write_cfg(esc_pkg::CfgPressCalibB, {16'h1770, 16'hF1AA, 16'hFFF9, 16'h008D});
		write_cfg(esc_pkg::CfgPressCalibC, 64'(16'd4285));
		write_cfg(esc_pkg::CfgHumCalib, {8'd30, 12'd50, 12'd312, 8'd0, 16'd359, 8'd75});
	endtask

	function automatic esc_pkg::in_t rand_triple();
		esc_pkg::in_t raw;
		raw.raw_temp = $urandom_range(4) == 0 ? 20'($urandom)
			: 20'($urandom_range(600000, 400000));
		raw.raw_press = $urandom_range(4) == 0 ? 20'($urandom)
			: 20'($urandom_range(450000, 250000));
		raw.raw_hum = $urandom_range(4) == 0 ? 16'($urandom)
			: 16'($urandom_range(40000, 20000));
		return raw;
	endfunction

	// field extremes with reset calibration (pressure divisor zero), typical and extreme ones
	task automatic test_directed();
		logic [19:0] ext20[3];
		logic [15:0] ext16[3];
		ext20 = '{20'd0, 20'hFFFFF, 20'h80000};
		ext16 = '{16'd0, 16'hFFFF, 16'h8000};
		send_idle_pct = 0;
		for (int i = 0; i < 3; i++)
			send_triple('{ext20[i], ext20[(i + 1) % 3], ext16[i]});
		drain();
		load_typical_cal();
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				send_triple('{ext20[i], ext20[j], ext16[(i + j) % 3]});
		send_triple('{20'd519888, 20'd415148, 16'd28000});
		send_triple('{20'd519888, 20'd415148, 16'd65535});
		drain();
		// unsigned words at full scale
		write_cfg(esc_pkg::CfgTempCalib, 64'(48'hFFFF_FFFF_FFFF));
		write_cfg(esc_pkg::CfgHumCalib, 64'hFFFF_FFFF_FFFF_FFFF);
		send_triple('{20'hFFFFF, 20'd0, 16'hFFFF});
		send_triple('{20'd0, 20'hFFFFF, 16'd0});
		drain();
		// most negative signed words
		write_cfg(esc_pkg::CfgTempCalib, 64'({16'h8000, 16'h8000, 16'd0}));
		write_cfg(esc_pkg::CfgPressCalibA, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
		write_cfg(esc_pkg::CfgPressCalibB, {4{16'h8000}});
		write_cfg(esc_pkg::CfgPressCalibC, 64'(16'h8000));
		write_cfg(esc_pkg::CfgHumCalib,
			{8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
		send_triple('{20'd519888, 20'd415148, 16'd28000});
		send_triple('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
		drain();
	endtask

	// random triples under one calibration set per phase, typical or random
	task automatic test_random_phase(int n_items, int idle_pct, bit typical);
		if (typical) begin
			load_typical_cal();
		end else begin
			write_cfg(esc_pkg::CfgTempCalib, {$urandom, $urandom});
			write_cfg(esc_pkg::CfgPressCalibA, {$urandom, $urandom});
			write_cfg(esc_pkg::CfgPressCalibB, {$urandom, $urandom});
			write_cfg(esc_pkg::CfgPressCalibC, 64'($urandom));
			write_cfg(esc_pkg::CfgHumCalib, {$urandom, $urandom});
		end
		send_idle_pct = idle_pct;
		for (int i = 0; i < n_items && !timed_out; i++) begin
			send_triple(typical ? rand_triple() : esc_pkg::in_t'({$urandom, $urandom}));
			// hold off once until the pipeline is empty
			if (i == n_items / 2) begin
				start <= 1'b0;
				while (compensated_q.size() != 0 && !timed_out)
					@(negedge clk);
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cal_temp = '0;
		cal_press_a = '0;
		cal_press_b = '0;
		cal_press_c = '0;
		cal_hum = '0;
		mismatch_cnt = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_phase(240, 0, 1'b1);
		test_random_phase(120, 45, 1'b0);
		test_random_phase(240, 45, 1'b1);
		test_random_phase(100, 13, 1'b0);
		test_random_phase(220, 13, 1'b1);

		if (timed_out || mismatch_cnt != 0 || compensated_q.size() != 0) begin
			$display("env_sensor_compensation_unit_tb: FAIL");
		end else begin
			$display("env_sensor_compensation_unit_tb: PASS");
		end
		$finish;
	end

	// stop a hung run
	always @(posedge clk) begin
		if (timed_out) begin
			$display("env_sensor_compensation_unit_tb: FAIL");
			$finish;
		end
	end

endmodule
